// ===== rtl/bnc_pkg.sv =====
// Shared types, constants and helper functions for the bracket nesting checker.
`timescale 1ns / 1ps

package bnc_pkg;

  // Default stack depth
  localparam int unsigned STACK_DEPTH_DEF = 64;

  // Field widths
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned ADDED_W  = 15;
  localparam int unsigned TOTAL_W  = 32;
  localparam int unsigned DEPTH_W  = 7;
  localparam int unsigned KIND_W   = 2;

  // Bracket characters
  localparam logic [CHAR_W-1:0] CH_OPEN_ROUND   = 8'h28; // (
  localparam logic [CHAR_W-1:0] CH_OPEN_SQUARE  = 8'h5B; // [
  localparam logic [CHAR_W-1:0] CH_OPEN_CURLY   = 8'h7B; // {
  localparam logic [CHAR_W-1:0] CH_OPEN_ANGLE   = 8'h3C; // <
  localparam logic [CHAR_W-1:0] CH_CLOSE_ROUND  = 8'h29; // )
  localparam logic [CHAR_W-1:0] CH_CLOSE_SQUARE = 8'h5D; // ]
  localparam logic [CHAR_W-1:0] CH_CLOSE_CURLY  = 8'h7D; // }
  localparam logic [CHAR_W-1:0] CH_CLOSE_ANGLE  = 8'h3E; // >

  // Bracket kinds
  localparam logic [KIND_W-1:0] KIND_ROUND  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CURLY  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ANGLE  = 2'd3;

  // Corruption scores
  localparam logic [ADDED_W-1:0] SCORE_ROUND  = 15'd3;
  localparam logic [ADDED_W-1:0] SCORE_SQUARE = 15'd57;
  localparam logic [ADDED_W-1:0] SCORE_CURLY  = 15'd1197;
  localparam logic [ADDED_W-1:0] SCORE_ANGLE  = 15'd25137;

  // Per-character status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OPENED   = 3'd0,
    ST_CLOSED   = 3'd1,
    ST_CORRUPT  = 3'd2,
    ST_SKIPPED  = 3'd3,
    ST_INVALID  = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_t;

  // Input transaction
  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              line_end;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDED_W-1:0]  added_score;
    logic [TOTAL_W-1:0]  total_score;
    logic [DEPTH_W-1:0]  open_depth;
  } out_t;

  // Stack command from the checker to the stack
  typedef struct packed {
    logic              push;
    logic              pop;
    logic              clear;
    logic [KIND_W-1:0] kind;
  } stack_op_t;

  // Bracket decode: valid flag and kind
  typedef struct packed {
    logic              hit;
    logic [KIND_W-1:0] kind;
  } kind_dec_t;

  function automatic kind_dec_t opener_kind(input logic [CHAR_W-1:0] c);
    kind_dec_t d;
    d.hit  = 1'b1;
    d.kind = KIND_ROUND;
    case (c)
      CH_OPEN_ROUND:  d.kind = KIND_ROUND;
      CH_OPEN_SQUARE: d.kind = KIND_SQUARE;
      CH_OPEN_CURLY:  d.kind = KIND_CURLY;
      CH_OPEN_ANGLE:  d.kind = KIND_ANGLE;
      default:        d.hit  = 1'b0;
    endcase
    return d;
  endfunction

  function automatic kind_dec_t closer_kind(input logic [CHAR_W-1:0] c);
    kind_dec_t d;
    d.hit  = 1'b1;
    d.kind = KIND_ROUND;
    case (c)
      CH_CLOSE_ROUND:  d.kind = KIND_ROUND;
      CH_CLOSE_SQUARE: d.kind = KIND_SQUARE;
      CH_CLOSE_CURLY:  d.kind = KIND_CURLY;
      CH_CLOSE_ANGLE:  d.kind = KIND_ANGLE;
      default:         d.hit  = 1'b0;
    endcase
    return d;
  endfunction

  function automatic logic [ADDED_W-1:0] closer_score(input logic [KIND_W-1:0] k);
    logic [ADDED_W-1:0] s;
    case (k)
      KIND_ROUND:  s = SCORE_ROUND;
      KIND_SQUARE: s = SCORE_SQUARE;
      KIND_CURLY:  s = SCORE_CURLY;
      default:     s = SCORE_ANGLE;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/bnc_stack.sv =====
// Bracket kind stack: top and next-below entries in registers, the rest in memory.
`timescale 1ns / 1ps

module bnc_stack #(
  parameter int unsigned STACK_DEPTH = bnc_pkg::STACK_DEPTH_DEF,
  localparam int unsigned SP_W  = $clog2(STACK_DEPTH + 1),
  localparam int unsigned IDX_W = $clog2(STACK_DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bnc_pkg::stack_op_t            op_i,
  output logic [SP_W-1:0]               depth_o,
  output logic [bnc_pkg::KIND_W-1:0]    top_kind_o
);
  import bnc_pkg::*;

  localparam logic [SP_W-1:0] SP_ONE   = SP_W'(1);
  localparam logic [SP_W-1:0] SP_THREE = SP_W'(3);

  logic [KIND_W-1:0] mem [STACK_DEPTH];
  logic [SP_W-1:0]   sp_r;
  logic [KIND_W-1:0] top_r;
  logic [KIND_W-1:0] below_r;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;

  // Fetch the entry that becomes next-below after a pop
  always_comb begin
    rd_en   = op_i.pop && (sp_r >= SP_THREE);
    rd_addr = rd_en ? IDX_W'(sp_r - SP_THREE) : '0;
    wr_addr = IDX_W'(sp_r);
  end

  // Write each pushed kind at its slot
  always_ff @(posedge clk) begin
    if (op_i.push) begin
      mem[wr_addr] <= op_i.kind;
    end
  end

  // Shift the cached top pair on push and pop
  always_ff @(posedge clk) begin
    if (op_i.push) begin
      top_r   <= op_i.kind;
      below_r <= top_r;
    end else if (op_i.pop) begin
      top_r <= below_r;
      if (rd_en) begin
        below_r <= mem[rd_addr];
      end
    end
  end

  // Track depth; line end empties the stack
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else if (op_i.clear) begin
      sp_r <= '0;
    end else if (op_i.push) begin
      sp_r <= sp_r + SP_ONE;
    end else if (op_i.pop) begin
      sp_r <= sp_r - SP_ONE;
    end
  end

  assign depth_o    = sp_r;
  assign top_kind_o = top_r;

endmodule

// ===== rtl/bracket_nesting_checker.sv =====
// Top level of the bracket nesting checker: handshakes, per-character decision, scoring.
//
//   Channel   Ports                          Direction  Content
//   input     in_valid, in_stall, in_data    in         one character, line-end flag
//   result    out_valid, out_stall, out_data out        status, score, total, depth
//
// One character per cycle sustained while the result is not stalled; each character is
// held in the input register and its result then in the result register. The rate is
// set by the stack update: the top two entries sit in registers and the memory read for
// the entry below them is issued on each pop from a depth of three or more, so pops may
// follow each other in consecutive cycles. Synchronous active-low reset clears the depth,
// the abandoned mark, the score total and both valid flags. A stalled result holds
// the pipeline; the input register still takes one character while the result waits.
`timescale 1ns / 1ps

module bracket_nesting_checker #(
  parameter int unsigned STACK_DEPTH = bnc_pkg::STACK_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  bnc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output bnc_pkg::out_t out_data
);
  import bnc_pkg::*;

  localparam int unsigned SP_W = $clog2(STACK_DEPTH + 1);
  localparam logic [SP_W-1:0] SP_ONE  = SP_W'(1);
  localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);

  // Input register
  logic      s1_valid_r;
  in_t       s1_data_r;
  // Result register
  logic      out_valid_r;
  out_t      out_data_r;
  // Checker state
  logic                 abandoned_r;
  logic [TOTAL_W-1:0]   sum_r;

  logic                 advance;
  logic                 accept;
  logic                 proc;
  logic [SP_W-1:0]      depth;
  logic [KIND_W-1:0]    top_kind;
  kind_dec_t            open_dec;
  kind_dec_t            close_dec;
  stack_op_t            op;
  status_t              status;
  logic [ADDED_W-1:0]   added;
  logic [TOTAL_W:0]     sum_wide;
  logic [TOTAL_W-1:0]   sum_nxt;
  logic                 abandoned_nxt;
  logic [SP_W-1:0]      depth_after;

  // Handshake control
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;
  assign proc     = s1_valid_r && advance;

  // Capture the incoming transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data_r <= in_data;
    end
  end

  bnc_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk        (clk),
    .rst_n      (rst_n),
    .op_i       (op),
    .depth_o    (depth),
    .top_kind_o (top_kind)
  );

  // Decide the character's effect
  always_comb begin
    open_dec      = opener_kind(s1_data_r.char_code);
    close_dec     = closer_kind(s1_data_r.char_code);
    op.push       = 1'b0;
    op.pop        = 1'b0;
    op.clear      = proc && s1_data_r.line_end;
    op.kind       = open_dec.kind;
    added         = '0;
    abandoned_nxt = abandoned_r;
    status        = ST_INVALID;
    if (abandoned_r) begin
      status = ST_SKIPPED;
    end else if (open_dec.hit) begin
      if (depth >= SP_FULL) begin
        status        = ST_OVERFLOW;
        abandoned_nxt = 1'b1;
      end else begin
        status  = ST_OPENED;
        op.push = proc;
      end
    end else if (close_dec.hit) begin
      if ((depth != '0) && (top_kind == close_dec.kind)) begin
        status = ST_CLOSED;
        op.pop = proc;
      end else begin
        status        = ST_CORRUPT;
        added         = closer_score(close_dec.kind);
        abandoned_nxt = 1'b1;
      end
    end
    if (s1_data_r.line_end) begin
      abandoned_nxt = 1'b0;
    end
  end

  // Saturating score accumulation
  always_comb begin
    sum_wide = {1'b0, sum_r} + {{(TOTAL_W + 1 - ADDED_W){1'b0}}, added};
    sum_nxt  = sum_wide[TOTAL_W] ? '1 : sum_wide[TOTAL_W-1:0];
  end

  // Depth after this character, before any line-end clear
  always_comb begin
    depth_after = depth;
    if (status == ST_OPENED) begin
      depth_after = depth + SP_ONE;
    end else if (status == ST_CLOSED) begin
      depth_after = depth - SP_ONE;
    end
  end

  // Advance checker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      abandoned_r <= 1'b0;
      sum_r       <= '0;
    end else if (proc) begin
      abandoned_r <= abandoned_nxt;
      sum_r       <= sum_nxt;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_data_r.status      <= status;
      out_data_r.added_score <= added;
      out_data_r.total_score <= sum_nxt;
      out_data_r.open_depth  <= DEPTH_W'(depth_after);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // Depth never exceeds the stack size
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth <= SP_FULL)
    else $error("stack depth beyond capacity");

  // A score is added only by a corrupting closer
  a_score_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r.added_score != '0) == (out_data_r.status == ST_CORRUPT)))
    else $error("added score and status disagree");

  // The running total never decreases
  a_sum_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (sum_r >= $past(sum_r)))
    else $error("score total decreased");

  // Input is held back only when the input register is occupied
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled without a pending transaction");
`endif

endmodule
